@@ rtl/oads_pkg.sv @@
// ----------------------------------------------------------------------------
// oads_pkg
// Shared types, state codes, the sequence table and the constant-divide
// helpers of the obstacle avoidance drive sequencer.
// ----------------------------------------------------------------------------
package oads_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_BLOCKED_DIST = 2'd0;
   localparam logic [1:0] CSR_MOTOR_RELOAD = 2'd1;
   localparam logic [1:0] CSR_SERVO_RELOAD = 2'd2;

   localparam logic [10:0] BLOCKED_DIST_RESET = 11'd30;
   localparam logic [15:0] MOTOR_RELOAD_RESET = 16'd66;
   localparam logic [15:0] SERVO_RELOAD_RESET = 16'd1999;

   // Sequencer states
   localparam logic [3:0] ST_FORWARD       = 4'd0;
   localparam logic [3:0] ST_STOP          = 4'd1;
   localparam logic [3:0] ST_LOOK_LEFT     = 4'd2;
   localparam logic [3:0] ST_TURN_LEFT     = 4'd3;
   localparam logic [3:0] ST_STOP_LEFT     = 4'd4;
   localparam logic [3:0] ST_LEFT_FORWARD  = 4'd5;
   localparam logic [3:0] ST_LOOK_RIGHT    = 4'd6;
   localparam logic [3:0] ST_TURN_RIGHT    = 4'd7;
   localparam logic [3:0] ST_STOP_RIGHT    = 4'd8;
   localparam logic [3:0] ST_RIGHT_FORWARD = 4'd9;
   localparam logic [3:0] ST_REVERSE       = 4'd10;
   localparam logic [3:0] ST_INIT_STOP     = 4'd11;

   // Motor speed classes (duty percentages 45, 50, 59, 60, 65)
   localparam int SPD_COUNT = 5;
   localparam logic [2:0] SPD_45 = 3'd0;
   localparam logic [2:0] SPD_50 = 3'd1;
   localparam logic [2:0] SPD_59 = 3'd2;
   localparam logic [2:0] SPD_60 = 3'd3;
   localparam logic [2:0] SPD_65 = 3'd4;

   // H-bridge pin patterns, bit0 IN1 .. bit3 IN4
   localparam logic [3:0] PINS_STOP    = 4'd0;
   localparam logic [3:0] PINS_FORWARD = 4'd9;
   localparam logic [3:0] PINS_LEFT    = 4'd10;
   localparam logic [3:0] PINS_RIGHT   = 4'd5;
   localparam logic [3:0] PINS_REVERSE = 4'd6;

   typedef struct packed {
      logic        moving;
      logic [3:0]  pins;
      logic [2:0]  pass_spd;
      logic [2:0]  drv_spd;
      logic [10:0] dwell;
      logic [3:0]  next_clear;
      logic [3:0]  next_blocked;
   } seq_entry_type;

   typedef struct packed {
      logic [10:0]                  blocked_dist;
      logic [SPD_COUNT-1:0][15:0]   motor_cmp;
      logic [15:0]                  servo_left;
      logic [15:0]                  servo_right;
      logic [15:0]                  servo_center;
   } oads_cfg_type;

   function automatic seq_entry_type seq_lookup(input logic [3:0] idx);
      seq_entry_type e;
      e = '{moving: 1'b0, pins: PINS_STOP, pass_spd: SPD_45, drv_spd: SPD_45,
            dwell: 11'd2000, next_clear: ST_FORWARD, next_blocked: ST_FORWARD};
      case (idx)
         ST_FORWARD: begin
            e = '{1'b1, PINS_FORWARD, SPD_59, SPD_60, 11'd0, ST_FORWARD, ST_STOP};
         end
         ST_STOP: begin
            e = '{1'b0, PINS_STOP, SPD_45, SPD_45, 11'd1000, ST_LOOK_LEFT, ST_LOOK_LEFT};
         end
         ST_LOOK_LEFT: begin
            e = '{1'b0, PINS_STOP, SPD_45, SPD_45, 11'd1000, ST_TURN_LEFT, ST_LOOK_RIGHT};
         end
         ST_TURN_LEFT: begin
            e = '{1'b1, PINS_LEFT, SPD_50, SPD_50, 11'd430, ST_STOP_LEFT, ST_STOP_LEFT};
         end
         ST_STOP_LEFT: begin
            e = '{1'b0, PINS_STOP, SPD_45, SPD_45, 11'd1000, ST_LEFT_FORWARD,
                  ST_LEFT_FORWARD};
         end
         ST_LEFT_FORWARD: begin
            e = '{1'b1, PINS_FORWARD, SPD_45, SPD_65, 11'd400, ST_FORWARD, ST_FORWARD};
         end
         ST_LOOK_RIGHT: begin
            e = '{1'b0, PINS_STOP, SPD_45, SPD_45, 11'd1000, ST_TURN_RIGHT, ST_REVERSE};
         end
         ST_TURN_RIGHT: begin
            e = '{1'b1, PINS_RIGHT, SPD_50, SPD_50, 11'd430, ST_STOP_RIGHT, ST_STOP_RIGHT};
         end
         ST_STOP_RIGHT: begin
            e = '{1'b0, PINS_STOP, SPD_45, SPD_45, 11'd1000, ST_RIGHT_FORWARD,
                  ST_RIGHT_FORWARD};
         end
         ST_RIGHT_FORWARD: begin
            e = '{1'b1, PINS_FORWARD, SPD_60, SPD_50, 11'd400, ST_FORWARD, ST_FORWARD};
         end
         ST_REVERSE: begin
            e = '{1'b1, PINS_REVERSE, SPD_60, SPD_50, 11'd400, ST_STOP, ST_STOP};
         end
         default: begin
            // initial stop, and any code beyond the table
            e = '{1'b0, PINS_STOP, SPD_45, SPD_45, 11'd2000, ST_FORWARD, ST_FORWARD};
         end
      endcase
      return e;
   endfunction

   function automatic logic [6:0] spd_pct(input logic [2:0] spd);
      logic [6:0] pct;
      case (spd)
         SPD_45:  pct = 7'd45;
         SPD_50:  pct = 7'd50;
         SPD_59:  pct = 7'd59;
         SPD_60:  pct = 7'd60;
         SPD_65:  pct = 7'd65;
         default: pct = 7'd0;
      endcase
      return pct;
   endfunction

   // floor(reload * pct / 100): multiply by ceil(2^30 / 100)
   function automatic logic [15:0] motor_scale(input logic [15:0] reload,
                                               input logic [6:0] pct);
      logic [22:0] x;
      logic [46:0] prod;
      x    = 23'(reload) * 23'(pct);
      prod = 47'(x) * 47'(24'd10737419);
      return prod[45:30];
   endfunction

   // floor(reload * 3 / 100): multiply by ceil(2^25 / 100)
   function automatic logic [15:0] servo_right_scale(input logic [15:0] reload);
      logic [17:0] x;
      logic [46:0] prod;
      x    = 18'(reload) * 18'd3;
      prod = 47'(x) * 47'(19'd335545);
      return prod[40:25];
   endfunction

   // floor(reload * 82 / 1000) = floor(reload * 41 / 500): ceil(2^31 / 500)
   function automatic logic [15:0] servo_center_scale(input logic [15:0] reload);
      logic [21:0] x;
      logic [46:0] prod;
      x    = 22'(reload) * 22'd41;
      prod = 47'(x) * 47'(23'd4294968);
      return prod[46:31];
   endfunction

   // floor(ticks * 17 / 1000) = floor(floor(ticks * 17 / 8) / 125)
   function automatic logic [10:0] echo_distance(input logic [15:0] ticks);
      logic [20:0] x;
      logic [36:0] prod;
      x    = {1'b0, ticks, 4'b0000} + 21'(ticks);
      prod = 37'(x[20:3]) * 37'(19'd268436);
      return prod[35:25];
   endfunction

endpackage

@@ rtl/oads_csr.sv @@
// ----------------------------------------------------------------------------
// oads_csr
// Configuration registers and the compare values scaled from them, kept in
// registers so the step logic sees finished numbers.
// ----------------------------------------------------------------------------
module oads_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   output oads_pkg::oads_cfg_type cfg
);

   logic [10:0] blocked_dist_ff;
   logic [15:0] motor_reload_ff;
   logic [15:0] servo_reload_ff;
   oads_pkg::oads_cfg_type cfg_ff;
   oads_pkg::oads_cfg_type cfg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_dist_ff <= oads_pkg::BLOCKED_DIST_RESET;
         motor_reload_ff <= oads_pkg::MOTOR_RELOAD_RESET;
         servo_reload_ff <= oads_pkg::SERVO_RELOAD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            oads_pkg::CSR_BLOCKED_DIST: blocked_dist_ff <= csr_wdata[10:0];
            oads_pkg::CSR_MOTOR_RELOAD: motor_reload_ff <= csr_wdata;
            oads_pkg::CSR_SERVO_RELOAD: servo_reload_ff <= csr_wdata;
            default: ; // drop writes to unknown registers
         endcase
      end
   end

   always_comb begin
      cfg_in.blocked_dist = blocked_dist_ff;
      for (int i = 0; i < oads_pkg::SPD_COUNT; i++) begin
         cfg_in.motor_cmp[i] = oads_pkg::motor_scale(motor_reload_ff,
                                                     oads_pkg::spd_pct(3'(i)));
      end
      cfg_in.servo_left   = {3'b000, servo_reload_ff[15:3]};
      cfg_in.servo_right  = oads_pkg::servo_right_scale(servo_reload_ff);
      cfg_in.servo_center = oads_pkg::servo_center_scale(servo_reload_ff);
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/oads_core.sv @@
// ----------------------------------------------------------------------------
// oads_core
// Input register, one table step and the result register; holds the
// sequencer state and the motor levels kept through stop states.
// ----------------------------------------------------------------------------
module oads_core (
   input  logic                   clock,
   input  logic                   reset,
   input  oads_pkg::oads_cfg_type cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_echo_ticks,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_state_index,
   output logic                   rsp_blocked,
   output logic [10:0]            rsp_distance_cm,
   output logic [3:0]             rsp_bridge_pins,
   output logic [15:0]            rsp_passenger_compare,
   output logic [15:0]            rsp_driver_compare,
   output logic [15:0]            rsp_servo_compare,
   output logic [10:0]            rsp_dwell_ms
);

   logic        a_valid_ff;
   logic [15:0] a_ticks_ff;
   logic        b_valid_ff;
   logic        b_valid_in;
   logic        advance;
   logic        accept;

   logic [3:0]  state_ff;
   logic [15:0] pass_lvl_ff;
   logic [15:0] drv_lvl_ff;

   logic [10:0] echo_cm;
   logic        blk;
   oads_pkg::seq_entry_type cur_ent;
   oads_pkg::seq_entry_type nxt_ent;
   logic [3:0]  nxt;
   logic [15:0] pass_in;
   logic [15:0] drv_in;
   logic [15:0] servo_in;

   logic [3:0]  state_index_ff;
   logic        blocked_ff;
   logic [10:0] distance_ff;
   logic [3:0]  pins_ff;
   logic [15:0] pass_cmp_ff;
   logic [15:0] drv_cmp_ff;
   logic [15:0] servo_ff;
   logic [10:0] dwell_ff;

   // move the held transaction into the result register when it is free
   assign advance    = a_valid_ff && (!b_valid_ff || !rsp_stall);
   assign req_stall  = a_valid_ff && !advance;
   assign accept     = req_valid && !req_stall;
   assign b_valid_in = advance || (b_valid_ff && rsp_stall);

   always_comb begin
      echo_cm = oads_pkg::echo_distance(a_ticks_ff);
      blk     = (echo_cm <= cfg.blocked_dist);
      cur_ent = oads_pkg::seq_lookup(state_ff);
      nxt     = blk ? cur_ent.next_blocked : cur_ent.next_clear;
      nxt_ent = oads_pkg::seq_lookup(nxt);
      // stop states keep the previous levels
      pass_in = nxt_ent.moving ? cfg.motor_cmp[nxt_ent.pass_spd] : pass_lvl_ff;
      drv_in  = nxt_ent.moving ? cfg.motor_cmp[nxt_ent.drv_spd] : drv_lvl_ff;
      case (nxt)
         oads_pkg::ST_LOOK_LEFT:  servo_in = cfg.servo_left;
         oads_pkg::ST_LOOK_RIGHT: servo_in = cfg.servo_right;
         default:                 servo_in = cfg.servo_center;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         state_ff    <= oads_pkg::ST_INIT_STOP;
         pass_lvl_ff <= 16'd0;
         drv_lvl_ff  <= 16'd0;
      end else begin
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (advance) begin
            a_valid_ff <= 1'b0;
         end
         b_valid_ff <= b_valid_in;
         if (advance) begin
            state_ff    <= nxt;
            pass_lvl_ff <= pass_in;
            drv_lvl_ff  <= drv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ticks_ff <= req_echo_ticks;
      end
      if (advance) begin
         state_index_ff <= nxt;
         blocked_ff     <= blk;
         distance_ff    <= echo_cm;
         pins_ff        <= nxt_ent.pins;
         pass_cmp_ff    <= pass_in;
         drv_cmp_ff     <= drv_in;
         servo_ff       <= servo_in;
         dwell_ff       <= nxt_ent.dwell;
      end
   end

   assign rsp_valid             = b_valid_ff;
   assign rsp_state_index       = state_index_ff;
   assign rsp_blocked           = blocked_ff;
   assign rsp_distance_cm       = distance_ff;
   assign rsp_bridge_pins       = pins_ff;
   assign rsp_passenger_compare = pass_cmp_ff;
   assign rsp_driver_compare    = drv_cmp_ff;
   assign rsp_servo_compare     = servo_ff;
   assign rsp_dwell_ms          = dwell_ff;

`ifndef SYNTHESIS
   a_state_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff <= oads_pkg::ST_INIT_STOP)
      else $error("sequencer state outside the table");

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> b_valid_ff)
      else $error("advanced transaction did not reach the result register");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && b_valid_ff && rsp_stall))
      else $error("input stalled with room downstream");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (state_index_ff == state_ff))
      else $error("shown state differs from sequencer state");
`endif

endmodule

@@ rtl/obstacle_avoid_drive_sequencer.sv @@
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_sequencer
// Echo width in, one obstacle avoidance step out: next state, H-bridge pins,
// motor and servo compares and dwell time.
// ----------------------------------------------------------------------------
// Each echo measurement is one transaction and yields exactly one result
// transaction. It passes through the input register, then the result
// register, and a new one can be accepted every cycle; the input stalls
// only while both registers are full and the result is stalled. Motor and
// servo compares are rescaled from the reload registers into a further
// register, so write configuration while idle.
// ----------------------------------------------------------------------------
module obstacle_avoid_drive_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_echo_ticks,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_state_index,
   output logic        rsp_blocked,
   output logic [10:0] rsp_distance_cm,
   output logic [3:0]  rsp_bridge_pins,
   output logic [15:0] rsp_passenger_compare,
   output logic [15:0] rsp_driver_compare,
   output logic [15:0] rsp_servo_compare,
   output logic [10:0] rsp_dwell_ms
);

   oads_pkg::oads_cfg_type cfg;

   oads_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   oads_core u_core (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_echo_ticks        (req_echo_ticks),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_state_index       (rsp_state_index),
      .rsp_blocked           (rsp_blocked),
      .rsp_distance_cm       (rsp_distance_cm),
      .rsp_bridge_pins       (rsp_bridge_pins),
      .rsp_passenger_compare (rsp_passenger_compare),
      .rsp_driver_compare    (rsp_driver_compare),
      .rsp_servo_compare     (rsp_servo_compare),
      .rsp_dwell_ms          (rsp_dwell_ms)
   );

endmodule
